// ----- hw/rtl/terminal_line_assembler_defines.svh -----
`ifndef TERMINAL_LINE_ASSEMBLER_DEFINES_SVH
`define TERMINAL_LINE_ASSEMBLER_DEFINES_SVH

// Assertion helpers for the line assembler datapath.
`ifndef ASSERT_OFF
`define TLA_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("line assembler check failed");
`define TLA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("line assembler check failed");
`else
`define TLA_ASSERT(label, clk, rstn, prop)
`define TLA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hw/rtl/tla_pkg.sv -----
package tla_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] DEL_BYTE  = 8'h7F;
    localparam logic [7:0] BS_BYTE   = 8'h08;
    localparam logic [7:0] NL_BYTE   = 8'h0A;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] CSI_OPEN  = 8'h5B;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7E;
    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef enum logic [1:0] {
        ACT_DATA  = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_IGNORE,
        KIND_APPEND,
        KIND_COMMIT,
        KIND_ERASE,
        KIND_CLEAR
    } kind_t;

    typedef struct packed {
        logic take_byte;
        logic append;
        logic clear;
        logic drop_one;
        logic rd_tail;
        logic rd_idx;
        logic emit_start;
        logic idx_inc;
        logic load_out;
        logic end_line;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  fill_zero;
        logic  rd_is_cont;
        logic  idx_is_last;
        logic  out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/tla_ctrl.sv -----
module tla_ctrl
    import tla_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BS_RD,
        ST_BS_CHK,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.take_byte = 1'b1;
                    case (stat.kind)
                        KIND_CLEAR:  cmd.clear = 1'b1;
                        KIND_APPEND: cmd.append = 1'b1;
                        KIND_COMMIT: begin
                            if (stat.fill_zero) begin
                                cmd.end_line = 1'b1;
                            end else begin
                                cmd.emit_start = 1'b1;
                                state_next     = ST_EM_RD;
                            end
                        end
                        KIND_ERASE: begin
                            if (!stat.fill_zero) begin
                                cmd.drop_one = 1'b1;
                                state_next   = ST_BS_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_BS_RD: begin
                if (stat.fill_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd_tail = 1'b1;
                    state_next  = ST_BS_CHK;
                end
            end
            ST_BS_CHK: begin
                if (stat.rd_is_cont) begin
                    cmd.drop_one = 1'b1;
                    state_next   = ST_BS_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD: begin
                cmd.rd_idx = 1'b1;
                state_next = ST_EM_LD;
            end
            ST_EM_LD: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    if (stat.idx_is_last) begin
                        cmd.end_line = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/tla_dp.sv -----
`include "terminal_line_assembler_defines.svh"

module tla_dp
    import tla_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    localparam int IDX_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    logic [7:0]        line_store_reg [LINE_BYTES];
    logic [7:0]        rd_data_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_minus;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  rd_addr;
    logic              ovf_reg;
    logic              ovf_next;
    logic              after_esc_reg;
    logic              after_esc_next;
    logic              in_csi_reg;
    logic              in_csi_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_trunc_reg;
    logic              full;
    logic              wr_en;
    logic              rd_en;
    action_t           act;

    assign act        = action_t'(s_tuser);
    assign full       = (fill_reg >= FILL_W'(LINE_BYTES));
    assign fill_minus = fill_reg - FILL_W'(1);
    assign rd_addr    = cmd.rd_tail ? fill_minus[IDX_W-1:0] : idx_reg;
    assign rd_en      = cmd.rd_tail || cmd.rd_idx;
    assign wr_en      = cmd.append && !full;

    always_comb begin
        stat             = '0;
        stat.kind        = KIND_IGNORE;
        stat.fill_zero   = (fill_reg == '0);
        stat.rd_is_cont  = ((rd_data_reg & CONT_MASK) == CONT_TAG);
        stat.idx_is_last = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);
        stat.out_free    = !out_valid_reg || m_tready;
        if (act == ACT_CLEAR) begin
            stat.kind = KIND_CLEAR;
        end else if (act == ACT_FLUSH) begin
            stat.kind = KIND_COMMIT;
        end else if (act == ACT_DATA && !in_csi_reg && !after_esc_reg) begin
            if (s_tdata == NL_BYTE || s_tdata == CR_BYTE) begin
                stat.kind = KIND_COMMIT;
            end else if (s_tdata == DEL_BYTE || s_tdata == BS_BYTE) begin
                stat.kind = KIND_ERASE;
            end else if (s_tdata != ESC_BYTE && s_tdata >= PRINT_LO) begin
                stat.kind = KIND_APPEND;
            end
        end
    end

    always_comb begin
        after_esc_next = after_esc_reg;
        in_csi_next    = in_csi_reg;
        if (cmd.clear) begin
            after_esc_next = 1'b0;
            in_csi_next    = 1'b0;
        end else if (cmd.take_byte && act == ACT_DATA) begin
            if (in_csi_reg) begin
                if (s_tdata >= CSI_FINAL_LO && s_tdata <= CSI_FINAL_HI) begin
                    in_csi_next = 1'b0;
                end
            end else if (after_esc_reg) begin
                after_esc_next = 1'b0;
                in_csi_next    = (s_tdata == CSI_OPEN);
            end else if (s_tdata == ESC_BYTE) begin
                after_esc_next = 1'b1;
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        idx_next  = idx_reg;
        if (cmd.clear || cmd.end_line) begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end else if (cmd.append) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end else if (cmd.drop_one) begin
            fill_next = fill_minus;
        end
        if (cmd.emit_start) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            after_esc_reg <= 1'b0;
            in_csi_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            after_esc_reg <= after_esc_next;
            in_csi_reg    <= in_csi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store_reg[fill_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= line_store_reg[rd_addr];
        end
        if (cmd.load_out) begin
            out_byte_reg  <= rd_data_reg;
            out_last_reg  <= stat.idx_is_last;
            out_trunc_reg <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_trunc_reg;

    `TLA_ASSERT(a_fill_in_range, aclk, aresetn, fill_reg <= FILL_W'(LINE_BYTES))
    `TLA_ASSERT(a_esc_flags_exclusive, aclk, aresetn, !(after_esc_reg && in_csi_reg))
    `TLA_ASSERT(a_no_output_overwrite, aclk, aresetn, cmd.load_out |-> stat.out_free)
    `TLA_ASSERT(a_drop_nonempty, aclk, aresetn, cmd.drop_one |-> !stat.fill_zero)
    `TLA_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

// ----- hw/rtl/terminal_line_assembler.sv -----
// Terminal line assembler: filters ANSI escape sequences out of a byte stream
// and emits each committed line as a burst of beats on the master channel.
// Slave channel: s_tdata carries the raw byte, s_tuser the action (data byte,
// flush of the pending line, or clear of the line and escape state). A beat is
// taken only while no backspace walk or line drain is in progress.
// Plain data, escape, flush of an empty line and clear beats leave the controller idle.
// A backspace removes one byte, then reads back each preceding byte and removes it
// while it is a UTF-8 continuation byte, stopping when the line is empty.
// A commit drains the line after the accepting step: each byte gets one memory
// read and then one output load, and the output load waits while the receiver
// cannot take the byte held in the output register.
// The next beat is accepted right after the last byte reaches the output
// register, even if it has not been taken yet.
// When the receiver stalls, the drain waits with the current byte held in the
// output register and the slave channel stays blocked.
// Reset clears the escape state, the line fill count, the overflow flag and the
// output valid flag; line memory contents are not cleared and are never read
// before they are written.
module terminal_line_assembler
    import tla_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] line_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] line_truncated
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tla_dp #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- test/tb.sv -----
module tb;
    import tla_pkg::*;

    localparam int          LINE_BYTES  = LINE_BYTES_DEF;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          DRAIN_WAIT  = 200;
    localparam int          LONG_STALL  = 400;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
        logic       line_trunc;
    } line_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int stall_left;
    int items_sent;
    int error_count;
    int cycle_count;

    // Line assembly state as the block should hold it.
    logic       esc_seen;
    logic       csi_active;
    logic       line_dropped;
    logic [7:0] line_buf [LINE_BYTES];
    int         line_len;
    line_beat_t expected_beats [$];

    terminal_line_assembler #(
        .LINE_BYTES(LINE_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic clear_line_state();
        esc_seen     = 1'b0;
        csi_active   = 1'b0;
        line_dropped = 1'b0;
        line_len     = 0;
    endtask

    task automatic commit_pending_line();
        line_beat_t beat;
        for (int i = 0; i < line_len; i++) begin
            beat.line_byte  = line_buf[i];
            beat.line_last  = (i == line_len - 1);
            beat.line_trunc = line_dropped;
            expected_beats.insert(expected_beats.size(), beat);
        end
        line_len     = 0;
        line_dropped = 1'b0;
    endtask

    task automatic assemble_byte(input logic [1:0] act, input logic [7:0] b);
        case (act)
            ACT_FLUSH: commit_pending_line();
            ACT_CLEAR: clear_line_state();
            ACT_DATA: begin
                if (csi_active) begin
                    if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI)
                        csi_active = 1'b0;
                end else if (esc_seen) begin
                    esc_seen = 1'b0;
                    if (b == CSI_OPEN)
                        csi_active = 1'b1;
                end else if (b == ESC_BYTE) begin
                    esc_seen = 1'b1;
                end else if (b == NL_BYTE || b == CR_BYTE) begin
                    commit_pending_line();
                end else if (b == DEL_BYTE || b == BS_BYTE) begin
                    // Backspace removes one byte and then the continuation bytes before it.
                    if (line_len > 0) begin
                        line_len--;
                        while (line_len > 0 && (line_buf[line_len - 1] & CONT_MASK) == CONT_TAG)
                            line_len--;
                    end
                end else if (b >= PRINT_LO) begin
                    if (line_len < LINE_BYTES) begin
                        line_buf[line_len] = b;
                        line_len++;
                    end else begin
                        line_dropped = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // The valid line is left high after a beat so that back-to-back beats need no toggle.
    task automatic send_beat(input logic [1:0] act, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do
            @(posedge aclk);
        while (!s_tready);
        assemble_byte(act, b);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_beat(ACT_DATA, b);
    endtask

    always @(posedge aclk) begin
        line_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected line beat, expected none, actual data %h last %b trunc %b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.line_byte) begin
                    $display("%0t: line byte mismatch, expected %h actual %h",
                             $time, want.line_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.line_last) begin
                    $display("%0t: last flag mismatch, expected %b actual %b",
                             $time, want.line_last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== want.line_trunc) begin
                    $display("%0t: truncation flag mismatch, expected %b actual %b",
                             $time, want.line_trunc, m_tuser);
                    error_count++;
                end
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left == 0 && stall_request != 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_printable_and_controls();
        send_data(NL_BYTE);
        send_beat(ACT_FLUSH, 8'hA5);
        send_data(PRINT_LO);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h1F);
        send_data(8'h7E);
        send_data(CR_BYTE);
    endtask

    // A newline inside a control sequence is swallowed and does not commit.
    task automatic test_escape_filter();
        send_data(ESC_BYTE);
        send_data("X");
        send_data(ESC_BYTE);
        send_data(CSI_OPEN);
        send_data(NL_BYTE);
        send_data(CSI_FINAL_LO);
        send_data(ESC_BYTE);
        send_data(CSI_OPEN);
        send_data(CSI_FINAL_HI);
        send_data("A");
        send_beat(ACT_FLUSH, 8'h5A);
    endtask

    task automatic test_backspace_utf8();
        send_data("a");
        send_data(8'hE2);
        send_data(8'h82);
        send_data(8'hAC);
        send_data(DEL_BYTE);
        send_data(BS_BYTE);
        send_data(BS_BYTE);
        send_data("b");
        send_data(NL_BYTE);
    endtask

    task automatic test_clear_and_unused();
        send_data("c");
        send_data(ESC_BYTE);
        send_beat(ACT_CLEAR, 8'hFF);
        send_data("d");
        send_beat(ACT_UNUSED, CR_BYTE);
        send_beat(ACT_FLUSH, 8'h00);
    endtask

    // The receiver holds off while an overlong line and more beats are offered.
    // A backspace after the overflow keeps the truncation flag set.
    task automatic test_overflow_under_backpressure();
        stall_request = LONG_STALL;
        repeat (LINE_BYTES + 4)
            send_data(8'($urandom_range(PRINT_LO, 8'h7E)));
        send_data(BS_BYTE);
        send_data(NL_BYTE);
        repeat (20)
            send_data(8'($urandom_range(PRINT_LO, 8'hFF)));
        send_data(CR_BYTE);
    endtask

    task automatic send_random_token();
        int         pick;
        int         n;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_data(8'($urandom_range(PRINT_LO, 8'h7E)));
        end else if (pick < 62) begin
            n = $urandom_range(1, 3);
            if (n == 1)
                lead = 8'hC0 | 8'($urandom_range(0, 31));
            else if (n == 2)
                lead = 8'hE0 | 8'($urandom_range(0, 15));
            else
                lead = 8'hF0 | 8'($urandom_range(0, 7));
            send_data(lead);
            repeat (n)
                send_data(CONT_TAG | 8'($urandom_range(0, 63)));
        end else if (pick < 72) begin
            send_data(ESC_BYTE);
            send_data(CSI_OPEN);
            repeat ($urandom_range(0, 3))
                send_data(8'($urandom_range(PRINT_LO, 8'h3F)));
            send_data(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
        end else if (pick < 76) begin
            send_data(ESC_BYTE);
            send_data(8'($urandom_range(0, 255)));
        end else if (pick < 86) begin
            send_data($urandom_range(0, 1) ? DEL_BYTE : BS_BYTE);
        end else if (pick < 90) begin
            send_data(8'($urandom_range(0, 8'h1F)));
        end else if (pick < 96) begin
            send_data(8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            send_beat(ACT_CLEAR, 8'($urandom_range(0, 255)));
        end else if (pick < 98) begin
            send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
            send_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random_lines(input int n_items);
        int goal;
        int n_tokens;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            if ($urandom_range(0, 9) == 0)
                n_tokens = $urandom_range(40, 75);
            else
                n_tokens = $urandom_range(0, 12);
            repeat (n_tokens)
                send_random_token();
            case ($urandom_range(0, 2))
                0:       send_data(NL_BYTE);
                1:       send_data(CR_BYTE);
                default: send_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= 8'h00;
        s_tuser       <= ACT_DATA;
        send_idle_pct = 9;
        recv_idle_pct = 82;
        stall_request = 0;
        stall_left    = 0;
        items_sent    = 0;
        error_count   = 0;
        cycle_count   = 0;
        clear_line_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_printable_and_controls();
        test_escape_filter();
        test_backspace_utf8();
        test_clear_and_unused();
        run_random_lines(100);

        send_idle_pct = 82;
        recv_idle_pct = 9;
        run_random_lines(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_overflow_under_backpressure();
        run_random_lines(100);

        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
